>>> rtl/core/ieh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ieh_pkg;

    // History ring geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int HIST_CNT_W    = 7;

    // Shared divider geometry
    localparam int DIV_DVD_W = 64;
    localparam int DIV_DSR_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 256;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 232;
    localparam int M_TUSER_W = 4;

    // Microseconds per millisecond
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // 2^36 / 1000 rounded up; exact quotient for numerators below 2^26
    localparam logic [26:0] MS_RECIP = 27'd68719477;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_INTERP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_EMPTY   = 2'd1,
        ERR_TOO_OLD = 2'd2,
        ERR_STOPPED = 2'd3
    } err_t;

    // One history entry as stored in memory
    typedef struct packed {
        logic [31:0]        tstamp;
        logic signed [31:0] sum_a;
        logic signed [31:0] sum_b;
        logic signed [31:0] abs_x;
        logic signed [31:0] abs_y;
        logic [31:0]        modifier;
    } entry_t;

    // Clamp a 34-bit signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/input_event_history_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// s_axis    in   tdata: event_time, frame_time_us, rel_a, rel_b, abs_x_in, abs_y_in,
//                modifier_in, stop_value; tuser: op
// m_axis    out  tdata: out_time, delta_a, delta_b, abs_x_out, abs_y_out, modifier_out,
//                history_count, average_interval; tuser: valid_res, error_code, all_emitted
// cfg       in   wr_en, addr 0 dummy_interval, 1 estimation_window
//
// One item at a time. Every item runs the us-to-ms conversion (four 16-bit digits by
// reciprocal multiply) and, with two or more entries, the average-interval division
// on the shared bit-serial divider. Interpolation adds a backward search that reads
// the history memory entry by entry and, unless it ends on an exact hit or past the
// newest entry, a ratio division on the same divider and a multiply/accumulate pass
// over the four interpolated lanes.
// Reset is synchronous; no memory clearing pass. A held result stalls only the
// end of the next item.
module input_event_history_interpolator
    import ieh_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] event_time, [94:32] frame_time_us, [126:95] rel_a, [158:127] rel_b,
    // [190:159] abs_x_in, [222:191] abs_y_in, [254:223] modifier_in, [255] stop_value
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [31:0] out_time, [63:32] delta_a, [95:64] delta_b, [127:96] abs_x_out,
    // [159:128] abs_y_out, [191:160] modifier_out, [198:192] history_count,
    // [230:199] average_interval, [231] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [0] valid_res, [2:1] error_code, [3] all_emitted
    output logic [M_TUSER_W-1:0]      m_tuser,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [7:0]           cfg_wr_data
);

    localparam int KW = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MS_DIV, ST_DISPATCH, ST_PUSH_WR, ST_SRCH_RD, ST_SRCH_CHK,
        ST_B_CAP, ST_R_DIV, ST_MUL, ST_ACC, ST_DELTA, ST_AVG_RD, ST_AVG_NEW,
        ST_AVG_OLD, ST_AVG_DIV, ST_OUT
    } state_t;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] i);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(p) + (CNT_W+1)'(i);
        if (s >= (CNT_W+1)'(HISTORY_DEPTH)) begin
            s = s - (CNT_W+1)'(HISTORY_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // Configuration registers
    logic [7:0] dummy_interval_reg;
    logic [6:0] est_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dummy_interval_reg <= 8'd12;
            est_window_reg     <= 7'd6;
        end else if (cfg_wr_en) begin
            if (cfg_addr == 1'b0) begin
                dummy_interval_reg <= cfg_wr_data;
            end else begin
                est_window_reg <= cfg_wr_data[6:0];
            end
        end
    end

    // History memory
    entry_t            mem [HISTORY_DEPTH];
    entry_t            rd_q_reg;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= mem[mem_raddr];
    end

    // Control and working registers
    state_t             state_reg;
    logic [1:0]         op_reg;
    logic [31:0]        ev_time_reg;
    logic [62:0]        frame_us_reg;
    logic signed [31:0] rel_a_reg, rel_b_reg, abs_x_reg, abs_y_reg;
    logic [31:0]        mod_in_reg;
    logic               stop_val_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic signed [31:0] isum_a_reg, isum_b_reg;
    logic               stopped_reg;
    logic               first_reg;
    logic [31:0]        point_reg;
    logic [CNT_W-1:0]   idx_reg;
    entry_t             a_reg, b_reg;
    logic [15:0]        ratio_reg;
    logic [1:0]         lane_reg;
    logic signed [49:0] prod_reg;
    logic signed [31:0] lerp_reg [4];
    logic [31:0]        tn_reg;
    logic               res_valid_reg;
    logic [1:0]         res_err_reg;
    logic [31:0]        res_time_reg;
    logic signed [31:0] res_da_reg, res_db_reg, res_x_reg, res_y_reg;
    logic [31:0]        res_mod_reg;
    logic [31:0]        avg_reg;
    logic               all_em_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic               div_start_reg;
    logic [DIV_DVD_W-1:0] div_dvd_reg;
    logic [DIV_DSR_W-1:0] div_dsr_reg;
    logic [9:0]         ms_rem_reg;
    logic [15:0]        ms_q_reg;
    logic [1:0]         ms_idx_reg;
    logic               ms_phase_reg;

    logic                 div_done;
    logic [DIV_DVD_W-1:0] div_q;

    ieh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // us-to-ms: long division by 1000, one 16-bit digit at a time (quotient phase, then remainder phase)
    logic [15:0] ms_chunk;
    logic [25:0] ms_v;
    logic [52:0] ms_prod;
    logic [25:0] ms_rem_nx;

    always_comb begin
        case (ms_idx_reg)
            2'd0:    ms_chunk = {1'b0, frame_us_reg[62:48]};
            2'd1:    ms_chunk = frame_us_reg[47:32];
            2'd2:    ms_chunk = frame_us_reg[31:16];
            default: ms_chunk = frame_us_reg[15:0];
        endcase
    end

    assign ms_v      = {ms_rem_reg, ms_chunk};
    assign ms_prod   = {27'd0, ms_v} * {26'd0, MS_RECIP};
    assign ms_rem_nx = ms_v - {10'd0, ms_q_reg} * 26'(US_PER_MS);

    // Window size: at least 2, then capped at the fill level
    logic [KW-1:0]    win;
    logic [KW-1:0]    k_win;
    logic [CNT_W-1:0] newest_i;
    logic [PTR_W-1:0] app_addr;

    assign win      = (est_window_reg < 7'd2) ? KW'(2) : KW'(est_window_reg);
    assign k_win    = (KW'(count_reg) < win) ? KW'(count_reg) : win;
    assign newest_i = count_reg - 1'b1;
    assign app_addr = (count_reg < CNT_W'(HISTORY_DEPTH)) ? slot_of(ptr_reg, count_reg)
                                                          : ptr_reg;

    // Push sums on top of the newest entry (zero right after the dummy)
    logic signed [31:0] prev_a, prev_b, push_a, push_b;
    assign prev_a = first_reg ? 32'sd0 : rd_q_reg.sum_a;
    assign prev_b = first_reg ? 32'sd0 : rd_q_reg.sum_b;
    assign push_a = sat32({{2{prev_a[31]}}, prev_a} + {{2{rel_a_reg[31]}}, rel_a_reg});
    assign push_b = sat32({{2{prev_b[31]}}, prev_b} + {{2{rel_b_reg[31]}}, rel_b_reg});

    // Memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = app_addr;
        mem_wdata = '{tstamp: ev_time_reg, sum_a: push_a, sum_b: push_b,
                      abs_x: abs_x_reg, abs_y: abs_y_reg, modifier: mod_in_reg};
        mem_raddr = slot_of(ptr_reg, newest_i);
        case (state_reg)
            ST_DISPATCH: begin
                if (op_reg == OP_PUSH && !stopped_reg && count_reg == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_of(ptr_reg, '0);
                    mem_wdata = '{tstamp: ev_time_reg - 32'(dummy_interval_reg),
                                  sum_a: 32'sd0, sum_b: 32'sd0, abs_x: abs_x_reg,
                                  abs_y: abs_y_reg, modifier: mod_in_reg};
                end
            end
            ST_PUSH_WR:  mem_we = 1'b1;
            ST_SRCH_RD:  mem_raddr = slot_of(ptr_reg, idx_reg);
            ST_SRCH_CHK: mem_raddr = slot_of(ptr_reg, idx_reg + 1'b1);
            ST_AVG_NEW:  mem_raddr = slot_of(ptr_reg, CNT_W'(KW'(count_reg) - k_win));
            default: ;
        endcase
    end

    // Interpolation lane operands
    logic signed [31:0] lane_f, lane_s;
    logic signed [32:0] lane_diff;
    logic signed [50:0] lane_acc;
    logic signed [50:0] lane_sh;
    logic [31:0]        n_dist, d_dist;

    always_comb begin
        case (lane_reg)
            2'd0:    begin lane_f = a_reg.sum_a; lane_s = b_reg.sum_a; end
            2'd1:    begin lane_f = a_reg.sum_b; lane_s = b_reg.sum_b; end
            2'd2:    begin lane_f = a_reg.abs_x; lane_s = b_reg.abs_x; end
            default: begin lane_f = a_reg.abs_y; lane_s = b_reg.abs_y; end
        endcase
    end

    assign lane_diff = {lane_s[31], lane_s} - {lane_f[31], lane_f};
    assign lane_acc  = {prod_reg[49], prod_reg} + 51'sd32768;
    assign lane_sh   = lane_acc >>> 16;
    assign n_dist    = point_reg - a_reg.tstamp;
    assign d_dist    = b_reg.tstamp - a_reg.tstamp;

    // Delta against running interpolated sums
    logic signed [31:0] da, db;
    assign da = sat32({{2{lerp_reg[0][31]}}, lerp_reg[0]} - {{2{isum_a_reg[31]}}, isum_a_reg});
    assign db = sat32({{2{lerp_reg[1][31]}}, lerp_reg[1]} - {{2{isum_b_reg[31]}}, isum_b_reg});

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            isum_a_reg    <= '0;
            isum_b_reg    <= '0;
            stopped_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg        <= s_tuser[1:0];
                        ev_time_reg   <= s_tdata[31:0];
                        frame_us_reg  <= s_tdata[94:32];
                        rel_a_reg     <= s_tdata[126:95];
                        rel_b_reg     <= s_tdata[158:127];
                        abs_x_reg     <= s_tdata[190:159];
                        abs_y_reg     <= s_tdata[222:191];
                        mod_in_reg    <= s_tdata[254:223];
                        stop_val_reg  <= s_tdata[255];
                        ms_rem_reg    <= '0;
                        ms_idx_reg    <= '0;
                        ms_phase_reg  <= 1'b0;
                        state_reg     <= ST_MS_DIV;
                    end
                end
                ST_MS_DIV: begin
                    if (!ms_phase_reg) begin
                        ms_q_reg     <= ms_prod[51:36];
                        ms_phase_reg <= 1'b1;
                    end else begin
                        // keep the low 32 quotient bits
                        ms_rem_reg   <= ms_rem_nx[9:0];
                        point_reg    <= {point_reg[15:0], ms_q_reg};
                        ms_phase_reg <= 1'b0;
                        ms_idx_reg   <= ms_idx_reg + 1'b1;
                        if (ms_idx_reg == 2'd3) begin
                            state_reg <= ST_DISPATCH;
                        end
                    end
                end
                ST_DISPATCH: begin
                    res_valid_reg <= 1'b0;
                    res_time_reg  <= '0;
                    res_da_reg    <= '0;
                    res_db_reg    <= '0;
                    res_x_reg     <= '0;
                    res_y_reg     <= '0;
                    res_mod_reg   <= '0;
                    case (op_reg)
                        OP_PUSH: begin
                            if (stopped_reg) begin
                                res_err_reg <= ERR_STOPPED;
                                state_reg   <= ST_AVG_RD;
                            end else begin
                                res_err_reg <= ERR_OK;
                                first_reg   <= (count_reg == '0);
                                if (count_reg == '0) begin
                                    // dummy entry just written
                                    count_reg  <= CNT_W'(1);
                                    isum_a_reg <= '0;
                                    isum_b_reg <= '0;
                                end
                                state_reg <= ST_PUSH_WR;
                            end
                        end
                        OP_INTERP: begin
                            if (count_reg == '0) begin
                                res_err_reg <= ERR_EMPTY;
                                state_reg   <= ST_AVG_RD;
                            end else begin
                                res_err_reg <= ERR_OK;
                                idx_reg     <= newest_i;
                                state_reg   <= ST_SRCH_RD;
                            end
                        end
                        OP_CLEAR: begin
                            res_err_reg <= ERR_OK;
                            count_reg   <= '0;
                            ptr_reg     <= '0;
                            isum_a_reg  <= '0;
                            isum_b_reg  <= '0;
                            state_reg   <= ST_AVG_RD;
                        end
                        default: begin
                            res_err_reg <= ERR_OK;
                            stopped_reg <= stop_val_reg;
                            state_reg   <= ST_AVG_RD;
                        end
                    endcase
                end
                ST_PUSH_WR: begin
                    if (count_reg < CNT_W'(HISTORY_DEPTH)) begin
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        ptr_reg <= slot_of(ptr_reg, CNT_W'(1));
                    end
                    state_reg <= ST_AVG_RD;
                end
                ST_SRCH_RD: state_reg <= ST_SRCH_CHK;
                ST_SRCH_CHK: begin
                    if (rd_q_reg.tstamp <= point_reg) begin
                        a_reg <= rd_q_reg;
                        if (rd_q_reg.tstamp == point_reg || idx_reg == newest_i) begin
                            // exact hit or beyond newest: copy entry
                            res_time_reg <= rd_q_reg.tstamp;
                            lerp_reg[0]  <= rd_q_reg.sum_a;
                            lerp_reg[1]  <= rd_q_reg.sum_b;
                            lerp_reg[2]  <= rd_q_reg.abs_x;
                            lerp_reg[3]  <= rd_q_reg.abs_y;
                            res_mod_reg  <= rd_q_reg.modifier;
                            state_reg    <= ST_DELTA;
                        end else begin
                            state_reg <= ST_B_CAP;
                        end
                    end else if (idx_reg == '0) begin
                        res_err_reg <= ERR_TOO_OLD;
                        state_reg   <= ST_AVG_RD;
                    end else begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_SRCH_RD;
                    end
                end
                ST_B_CAP: begin
                    b_reg         <= rd_q_reg;
                    div_dvd_reg   <= {16'd0, point_reg - a_reg.tstamp, 16'd0};
                    div_dsr_reg   <= rd_q_reg.tstamp - a_reg.tstamp;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_R_DIV;
                end
                ST_R_DIV: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        ratio_reg    <= div_q[15:0];
                        lane_reg     <= 2'd0;
                        res_time_reg <= point_reg;
                        res_mod_reg  <= ({n_dist, 1'b0} < {1'b0, d_dist}) ? a_reg.modifier
                                                                         : b_reg.modifier;
                        state_reg    <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= 50'(lane_diff * $signed({1'b0, ratio_reg}));
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    lerp_reg[lane_reg] <= lane_f + lane_sh[31:0];
                    lane_reg           <= lane_reg + 1'b1;
                    state_reg          <= (lane_reg == 2'd3) ? ST_DELTA : ST_MUL;
                end
                ST_DELTA: begin
                    res_valid_reg <= 1'b1;
                    res_da_reg    <= da;
                    res_db_reg    <= db;
                    res_x_reg     <= lerp_reg[2];
                    res_y_reg     <= lerp_reg[3];
                    isum_a_reg    <= sat32({{2{isum_a_reg[31]}}, isum_a_reg}
                                           + {{2{da[31]}}, da});
                    isum_b_reg    <= sat32({{2{isum_b_reg[31]}}, isum_b_reg}
                                           + {{2{db[31]}}, db});
                    state_reg     <= ST_AVG_RD;
                end
                ST_AVG_RD: begin
                    if (count_reg == '0) begin
                        avg_reg    <= '0;
                        all_em_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end else begin
                        state_reg <= ST_AVG_NEW;
                    end
                end
                ST_AVG_NEW: begin
                    tn_reg     <= rd_q_reg.tstamp;
                    all_em_reg <= point_reg >= rd_q_reg.tstamp;
                    state_reg  <= ST_AVG_OLD;
                end
                ST_AVG_OLD: begin
                    if (count_reg < CNT_W'(2)) begin
                        avg_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        div_dvd_reg   <= {32'd0, tn_reg - rd_q_reg.tstamp};
                        div_dsr_reg   <= DIV_DSR_W'(k_win - 1'b1);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_AVG_DIV;
                    end
                end
                ST_AVG_DIV: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        avg_reg   <= div_q[31:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, avg_reg, HIST_CNT_W'(count_reg),
                                         res_mod_reg, res_y_reg, res_x_reg,
                                         res_db_reg, res_da_reg, res_time_reg};
                        m_tuser_reg  <= {all_em_reg, res_err_reg, res_valid_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // fill level never passes the ring depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    // an accepted item keeps the input closed on the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // a produced event carries no error code
    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ERR_OK))
        else $error("valid result with error code");

    // divider is only started from a division wait
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> (state_reg == ST_R_DIV || state_reg == ST_AVG_DIV))
        else $error("divider start outside a division wait");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ieh_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ieh_div
    import ieh_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_DVD_W-1:0] dividend,
    input  wire logic [DIV_DSR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_DVD_W-1:0]      quotient
);

    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DSR_W-1:0] dsr_reg;
    logic [DIV_DSR_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DSR_W:0]   rem_sh;
    logic                 fits;

    // shift in next dividend bit and trial-subtract
    assign rem_sh = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_DVD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? DIV_DSR_W'(rem_sh - {1'b0, dsr_reg})
                                : rem_sh[DIV_DSR_W-1:0];
                dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire
